FILE: rtl/trq_pkg.sv
// Shared types and constants for the trackball quaternion core.
`default_nettype none
package trq_pkg;
	localparam int FracBitsDef = 14;
	localparam int CfgW = 13;
	localparam int PosW = 14;
	localparam int QuatW = 16;
	localparam int OutOne = 16384;
	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] RegWidth = 1'b0;
	localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;
	localparam logic [CfgW-1:0] WidthRst = 13'd1024;
	localparam logic [CfgW-1:0] HeightRst = 13'd768;
	localparam int QDepth = 2;

	typedef enum logic [0:0] {
		CMD_ANCHOR = 1'b0,
		CMD_ROTATE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t             command;
		logic [PosW-1:0]  x_pos;
		logic [PosW-1:0]  y_pos;
	} item_t;
endpackage
`default_nettype wire

FILE: rtl/trq_divsqrt.sv
// Shared bit-serial restoring divider and integer square root unit.
`default_nettype none
module trq_divsqrt import trq_pkg::*; #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         is_sqrt,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic [W-1:0]      res
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] rem_q, quo_q, den_q, bit_q, v_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, sqrt_q;
	logic [W:0] trial;
	logic [W-1:0] rem_sh;

	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			sqrt_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sqrt_q <= is_sqrt;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
			v_q <= num;
			bit_q <= {2'b01, {(W-2){1'b0}}};
		end else if (busy_q) begin
			if (sqrt_q) begin
				// one result bit per cycle; idle once the trial bit runs out
				if (bit_q != '0) begin
					if (v_q >= rem_q + bit_q) begin
						v_q <= v_q - (rem_q + bit_q);
						rem_q <= (rem_q >> 1) + bit_q;
					end else begin
						rem_q <= rem_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end else begin
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end
		end
	end

	assign res = sqrt_q ? rem_q : quo_q;
endmodule
`default_nettype wire

FILE: rtl/trq_front.sv
// Front end: input acceptance and a two-entry item queue.
`default_nettype none
module trq_front import trq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  item_t      in_item,
	output logic       full,
	input  wire logic  take,
	output logic       avail,
	output item_t      head
);
	item_t mem_q [QDepth];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	logic acc;

	assign full = (cnt_q == 2'(QDepth));
	assign avail = (cnt_q != '0);
	assign acc = push && !full;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (acc) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) wp_q <= wp_q + 1'b1;
			if (take) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(acc) - 2'(take);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/trq_back.sv
// Back end: projection, cross product and quaternion normalization sequencer.
`default_nettype none
module trq_back import trq_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [CfgW-1:0] width,
	input  wire logic [CfgW-1:0] height,
	input  wire logic            avail,
	input  item_t                head,
	output logic                 take,
	output logic                 empty,
	input  wire logic            pop,
	output logic [QuatW-1:0]     quat_w,
	output logic [QuatW-1:0]     quat_x,
	output logic [QuatW-1:0]     quat_y,
	output logic [QuatW-1:0]     quat_z
);
	localparam int F = FRAC_BITS;
	localparam int CW = F + 3;          // Q2.F coordinate
	localparam int DW = 64;
	localparam int K = (F > 26) ? F - 26 : 0;
	localparam int MW = F + 4 - K;      // axis magnitude bits

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001, S_NX = 16'h0002, S_NXW = 16'h0004, S_NY = 16'h0008,
		S_NYW = 16'h0010, S_R2 = 16'h0020, S_ZSQ = 16'h0040, S_ZSW = 16'h0080,
		S_HDV = 16'h0100, S_HDW = 16'h0200, S_CRS = 16'h0400, S_NRM = 16'h0800,
		S_NSQ = 16'h1000, S_DIV = 16'h2000, S_DVW = 16'h4000, S_OUT = 16'h8000
	} state_t;

	state_t st_q;
	logic signed [CW-1:0] ax_q, ay_q, az_q, px_q, py_q, pz_q;
	logic [DW-1:0] r2_q, m_q [3], nrm_q, n2_q;
	logic neg_q [3];
	logic [1:0] idx_q, cidx_q;
	logic [QuatW-1:0] qv_q [4];
	cmd_t cmd_q;
	logic out_v_q;
	logic is_sqrt_q;
	logic signed [PosW:0] sx_q, sy_q;
	logic [CfgW-1:0] w_q, h_q;
	logic start, is_sqrt, dn;
	logic [DW-1:0] num, den, res;
	logic signed [2*CW:0] cr_q, cr_a, cr_b;
	logic [DW-1:0] cr_mag;
	logic [MW-1:0] mul_in;
	logic [2*MW-1:0] m_sq;

	trq_divsqrt #(.W(DW)) u_div (
		.clk, .arst_n, .start, .is_sqrt, .num, .den, .done(dn), .res
	);

	// signed numerator times one, divided by dim, truncated toward zero, saturated
	logic signed [DW-1:0] nnum;
	logic nneg;
	logic [DW-1:0] nmag;
	logic signed [DW-1:0] qsat;
	always_comb begin
		nnum = (st_q == S_NX) ? (DW'(sx_q) * 2 - DW'(signed'({1'b0, w_q})))
			: (DW'(signed'({1'b0, h_q})) - DW'(sy_q) * 2);
		nneg = nnum[DW-1];
		nmag = nneg ? DW'(-nnum) : DW'(nnum);
	end

	function automatic logic signed [CW-1:0] sat(input logic [DW-1:0] q, input logic ng);
		logic signed [DW-1:0] s;
		s = ng ? -signed'(q) : signed'(q);
		if (s > (DW'(2) <<< F) - 1) s = (DW'(2) <<< F) - 1;
		if (s < -(DW'(2) <<< F)) s = -(DW'(2) <<< F);
		return CW'(s);
	endfunction

	always_comb begin
		start = 1'b0;
		is_sqrt = 1'b0;
		num = '0;
		den = '0;
		unique case (st_q)
			S_NX, S_NY: begin
				start = 1'b1;
				num = nmag << F;
				den = DW'((st_q == S_NX) ? w_q : h_q);
			end
			S_ZSQ: begin
				start = 1'b1;
				is_sqrt = 1'b1;
				num = (r2_q <= (DW'(1) << (2*F - 1))) ? (DW'(1) << (2*F)) - r2_q : r2_q;
			end
			S_HDV: begin
				start = 1'b1;
				num = DW'(1) << (2*F);
				den = nrm_q << 1;
			end
			S_NSQ: begin
				start = 1'b1;
				is_sqrt = 1'b1;
				num = n2_q;
			end
			S_DIV: begin
				start = 1'b1;
				num = ((idx_q == 2'd0) ? (DW'(1) << (F - K)) : m_q[idx_q - 2'd1]) * OutOne;
				den = (nrm_q == '0) ? DW'(1) : nrm_q;
			end
			default: ;
		endcase
	end

	logic nneg_q;
	always_comb begin
		unique case (cidx_q)
			2'd0: begin cr_a = ay_q * pz_q; cr_b = az_q * py_q; end
			2'd1: begin cr_a = az_q * px_q; cr_b = ax_q * pz_q; end
			default: begin cr_a = ax_q * py_q; cr_b = ay_q * px_q; end
		endcase
		cr_mag = cr_q[2*CW] ? DW'(-cr_q) : DW'(cr_q);
		mul_in = m_q[idx_q][MW-1:0];
		m_sq = mul_in * mul_in;
	end

	assign take = (st_q == S_IDLE) && avail && !out_v_q;
	assign empty = !out_v_q;
	assign quat_w = qv_q[0];
	assign quat_x = qv_q[1];
	assign quat_y = qv_q[2];
	assign quat_z = qv_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_v_q <= 1'b0;
			is_sqrt_q <= 1'b0;
			ax_q <= '0;
			ay_q <= '0;
			az_q <= CW'(1) <<< F;
		end else begin
			if (pop && out_v_q) out_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (take) begin
					cmd_q <= head.command;
					sx_q <= (PosW+1)'(signed'(head.x_pos));
					sy_q <= (PosW+1)'(signed'(head.y_pos));
					w_q <= (width == '0) ? CfgW'(1) : width;
					h_q <= (height == '0) ? CfgW'(1) : height;
					st_q <= S_NX;
				end
				S_NX: begin nneg_q <= nneg; st_q <= S_NXW; end
				S_NXW: if (dn) begin px_q <= sat(res, nneg_q); st_q <= S_NY; end
				S_NY: begin nneg_q <= nneg; st_q <= S_NYW; end
				S_NYW: if (dn) begin py_q <= sat(res, nneg_q); st_q <= S_R2; end
				S_R2: begin
					r2_q <= DW'(px_q * px_q) + DW'(py_q * py_q);
					st_q <= S_ZSQ;
				end
				S_ZSQ: st_q <= S_ZSW;
				S_ZSW: if (dn) begin
					if (r2_q <= (DW'(1) << (2*F - 1))) begin
						pz_q <= CW'(res);
						if (cmd_q == CMD_ANCHOR) st_q <= S_OUT;
						else begin cidx_q <= 2'd0; idx_q <= 2'd0; st_q <= S_CRS; end
					end else begin
						nrm_q <= res;
						st_q <= S_HDV;
					end
				end
				S_HDV: st_q <= S_HDW;
				S_HDW: if (dn) begin
					pz_q <= CW'(res);
					if (cmd_q == CMD_ANCHOR) st_q <= S_OUT;
					else begin cidx_q <= 2'd0; idx_q <= 2'd0; st_q <= S_CRS; end
				end
				S_CRS: begin
					// first register the product difference, then reduce it
					if (idx_q == 2'd0) begin
						cr_q <= cr_a - cr_b;
						idx_q <= 2'd1;
					end else begin
						neg_q[cidx_q] <= cr_q[2*CW];
						m_q[cidx_q] <= (cr_mag >> F) >> K;
						idx_q <= 2'd0;
						if (cidx_q == 2'd2) begin
							n2_q <= (DW'(1) << (F - K)) * (DW'(1) << (F - K));
							st_q <= S_NRM;
						end else cidx_q <= cidx_q + 2'd1;
					end
				end
				S_NRM: begin
					n2_q <= n2_q + DW'(m_sq);
					if (idx_q == 2'd2) begin idx_q <= 2'd0; st_q <= S_NSQ; end
					else idx_q <= idx_q + 2'd1;
				end
				S_NSQ: begin is_sqrt_q <= 1'b1; st_q <= S_DVW; end
				S_DIV: st_q <= S_DVW;
				S_DVW: if (dn) begin
					if (is_sqrt_q) begin
						nrm_q <= res;
						is_sqrt_q <= 1'b0;
						st_q <= S_DIV;
					end else begin
						qv_q[idx_q] <= (idx_q != 2'd0 && neg_q[idx_q - 2'd1])
							? QuatW'(-res) : QuatW'(res);
						if (idx_q == 2'd3) st_q <= S_OUT;
						else begin idx_q <= idx_q + 2'd1; st_q <= S_DIV; end
					end
				end
				S_OUT: begin
					ax_q <= px_q;
					ay_q <= py_q;
					az_q <= pz_q;
					if (cmd_q == CMD_ROTATE) out_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/trackball_rotation_quaternion_core.sv
// Top level of the trackball rotation quaternion core.
//  channel | direction | handshake        | payload
//  input   | in        | push / full      | command, x_pos, y_pos
//  result  | out       | pop / empty      | quat_w, quat_x, quat_y, quat_z
//  config  | in        | cfg_we           | cfg_index, cfg_data
// Each item makes up to nine passes through the shared 64-step divide/square-root
// unit; an item on the hyperbolic sheet makes one pass more.
// Reset clears the queue, the sequencer and sets the anchor to (0, 0, one).
// A waiting result holds the back end; the front queue keeps taking two items.
`default_nettype none
module trackball_rotation_quaternion_core import trq_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               command,
	input  wire logic [PosW-1:0]    x_pos,
	input  wire logic [PosW-1:0]    y_pos,
	output logic                    empty,
	input  wire logic               pop,
	output logic [QuatW-1:0]        quat_w,
	output logic [QuatW-1:0]        quat_x,
	output logic [QuatW-1:0]        quat_y,
	output logic [QuatW-1:0]        quat_z,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data
);
	logic [CfgW-1:0] width_q, height_q;
	item_t in_item, head;
	logic take, avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WidthRst;
			height_q <= HeightRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegWidth: width_q <= cfg_data;
				RegHeight: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_item = '{command: cmd_t'(command), x_pos: x_pos, y_pos: y_pos};

	trq_front u_front (
		.clk, .arst_n, .push, .in_item, .full, .take, .avail, .head
	);

	trq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .width(width_q), .height(height_q), .avail, .head, .take,
		.empty, .pop, .quat_w, .quat_x, .quat_y, .quat_z
	);

	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> avail) else $error("back end took from empty queue");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(quat_w) && $stable(quat_z)))
		else $error("result changed while waiting");
	a_no_take_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !take) else $error("item taken while result waits");
endmodule
`default_nettype wire
